### rtl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg: shared types and codes of the indicator pattern controller
// Operation, pattern, status and register codes, plus the structs that pass
// between the top level, the lamp slices and the result queue.
// ----------------------------------------------------------------------------
package ipc_pkg;

	// Number of lamps (1 to 16)
	localparam int LAMPS = 5;
	// Lamps shown in the level field of a result
	localparam int LEVEL_BITS = 5;

	// Operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_PULSE = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	// Pattern codes
	localparam logic [2:0] PAT_OFF   = 3'd0;
	localparam logic [2:0] PAT_SOLID = 3'd1;
	localparam logic [2:0] PAT_SLOW  = 3'd2;
	localparam logic [2:0] PAT_FAST  = 3'd3;
	localparam logic [2:0] PAT_PULSE = 3'd4;

	// Status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_LAMP  = 2'd1;
	localparam logic [1:0] STAT_BAD_PATRN = 2'd2;

	// Register indexes
	localparam logic [1:0] CFG_SLOW_HALF  = 2'd0;
	localparam logic [1:0] CFG_FAST_HALF  = 2'd1;
	localparam logic [1:0] CFG_PULSE_LEN  = 2'd2;

	// Register reset values
	localparam logic [15:0] SLOW_HALF_RST = 16'd5;
	localparam logic [15:0] FAST_HALF_RST = 16'd2;
	localparam logic [15:0] PULSE_LEN_RST = 16'd2;

	typedef struct packed {
		logic [15:0] slow_half;
		logic [15:0] fast_half;
		logic [15:0] pulse_len;
	} cfg_t;

	// Per-lamp command for one accepted beat
	typedef struct packed {
		logic       tick;
		logic       set;
		logic       pulse;
		logic [2:0] pattern;
	} lamp_cmd_t;

	// Per-lamp visible state
	typedef struct packed {
		logic [2:0]  pattern;
		logic        lit;
		logic [31:0] transitions;
	} lamp_state_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [LEVEL_BITS-1:0] lamp_levels;
		logic [2:0]            query_pattern;
		logic                  query_lit;
		logic [31:0]           query_transitions;
	} result_t;

endpackage

### rtl/indicator_pattern_controller.sv
// ----------------------------------------------------------------------------
// indicator_pattern_controller: per-lamp blink, pulse and status engine
// Top level: input decode, configuration registers, lamp slices, result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (op, indicator, pattern) arrive on in_valid/in_ready. Each
//   accepted beat gives exactly one result beat (status, lamp_levels and the
//   query fields) on out_valid/out_ready, in order.
//   Each result is written into the result queue at the edge that accepts its
//   beat. Throughput is one beat per cycle while the queue has room; all lamps
//   update in parallel in one pass of per-lamp counter and compare logic ahead
//   of the lamp state registers.
//   A two-entry result queue sits at the output. While the receiver stalls,
//   up to two results wait there and in_ready drops only when both are full.
//   Registers are written through cfg_we/cfg_index/cfg_data at once; write
//   them only while no beat is in flight. Index 0 is the slow half period,
//   1 the fast half period, 2 the pulse length; other indexes are ignored.
//   Reset (arst_n low) turns every lamp off, clears all counts, empties the
//   queue and loads the register defaults (5, 2, 2).
// ----------------------------------------------------------------------------
module indicator_pattern_controller
	import ipc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [3:0]            indicator,
	input  logic [2:0]            pattern,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [LEVEL_BITS-1:0] lamp_levels,
	output logic [2:0]            query_pattern,
	output logic                  query_lit,
	output logic [31:0]           query_transitions,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	cfg_t        cfg_q;
	logic        accept;
	logic        in_range;
	logic        pat_valid;
	lamp_cmd_t   cmd [LAMPS];
	lamp_state_t lamp_st [LAMPS];
	logic [LAMPS-1:0] lit_next;
	logic [LEVEL_BITS-1:0] levels_next;
	result_t     res;
	result_t     out_data;

	assign accept    = in_valid && in_ready;
	assign in_range  = ({1'b0, indicator} < 5'(LAMPS));
	assign pat_valid = (pattern <= PAT_PULSE);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_half <= SLOW_HALF_RST;
			cfg_q.fast_half <= FAST_HALF_RST;
			cfg_q.pulse_len <= PULSE_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLOW_HALF: cfg_q.slow_half <= cfg_data;
				CFG_FAST_HALF: cfg_q.fast_half <= cfg_data;
				CFG_PULSE_LEN: cfg_q.pulse_len <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode the beat into per-lamp commands and instantiate the lamps
	for (genvar i = 0; i < LAMPS; i++) begin : g_lamp
		logic sel;
		assign sel             = (indicator == 4'(i));
		assign cmd[i].tick     = accept && (op == OP_TICK);
		assign cmd[i].set      = accept && (op == OP_SET) && sel && pat_valid;
		assign cmd[i].pulse    = accept && (op == OP_PULSE) && sel;
		assign cmd[i].pattern  = pattern;

		ipc_lamp u_lamp (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd[i]),
			.cfg      (cfg_q),
			.state    (lamp_st[i]),
			.lit_next (lit_next[i])
		);
	end

	// Drive the level field from the post-update lamp levels
	for (genvar b = 0; b < LEVEL_BITS; b++) begin : g_level
		if (b < LAMPS) begin : g_on
			assign levels_next[b] = lit_next[b];
		end else begin : g_off
			assign levels_next[b] = 1'b0;
		end
	end

	// Form status and query fields
	always_comb begin
		res.status            = STAT_OK;
		res.lamp_levels       = levels_next;
		res.query_pattern     = PAT_OFF;
		res.query_lit         = 1'b0;
		res.query_transitions = 32'd0;
		if (op != OP_TICK) begin
			if (!in_range) begin
				res.status = STAT_BAD_LAMP;
			end else if ((op == OP_SET) && !pat_valid) begin
				res.status = STAT_BAD_PATRN;
			end else if (op == OP_QUERY) begin
				for (int i = 0; i < LAMPS; i++) begin
					if (indicator == 4'(i)) begin
						res.query_pattern     = lamp_st[i].pattern;
						res.query_lit         = lamp_st[i].lit;
						res.query_transitions = lamp_st[i].transitions;
					end
				end
			end
		end
	end

	ipc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.not_full  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign status            = out_data.status;
	assign lamp_levels       = out_data.lamp_levels;
	assign query_pattern     = out_data.query_pattern;
	assign query_lit         = out_data.query_lit;
	assign query_transitions = out_data.query_transitions;

	// Every accepted beat has a result waiting after the edge
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted beat left no result");

	// Failed results carry empty query fields
	a_query_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STAT_OK)) |->
		((query_pattern == PAT_OFF) && !query_lit && (query_transitions == 32'd0)))
		else $error("query fields set on a failed request");

endmodule

### rtl/ipc_lamp.sv
// ----------------------------------------------------------------------------
// ipc_lamp: state and update logic of one indicator lamp
// Holds pattern, saved pattern, phase, pulse countdown, level and transition
// count, and applies one tick, set or pulse command per cycle.
// ----------------------------------------------------------------------------
module ipc_lamp
	import ipc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  lamp_cmd_t   cmd,
	input  cfg_t        cfg,
	output lamp_state_t state,
	output logic        lit_next
);

	logic [2:0]  cur_q, cur_d;
	logic [2:0]  sav_q, sav_d;
	logic [15:0] ph_q, ph_d;
	logic [15:0] rem_q, rem_d;
	logic        lit_q, lit_d;
	logic [31:0] tr_q, tr_d;

	logic        drv_en;
	logic        drv_lvl;
	logic        adopt;
	logic [2:0]  adopt_pat;
	logic [15:0] rem_dec;
	logic [16:0] ph_inc;
	logic [15:0] half;
	logic [15:0] plen_eff;

	assign rem_dec  = (rem_q != 16'd0) ? rem_q - 16'd1 : 16'd0;
	assign ph_inc   = {1'b0, ph_q} + 17'd1;
	assign half     = (cur_q == PAT_SLOW) ? cfg.slow_half : cfg.fast_half;
	assign plen_eff = (cfg.pulse_len != 16'd0) ? cfg.pulse_len : 16'd1;

	// Compute next lamp state
	always_comb begin
		cur_d     = cur_q;
		sav_d     = sav_q;
		ph_d      = ph_q;
		rem_d     = rem_q;
		drv_en    = 1'b0;
		drv_lvl   = 1'b0;
		adopt     = 1'b0;
		adopt_pat = cur_q;

		if (cmd.tick) begin
			case (cur_q) inside
				PAT_PULSE: begin
					rem_d = rem_dec;
					if (rem_dec == 16'd0) begin
						adopt     = 1'b1;
						adopt_pat = sav_q;
					end
				end
				PAT_SLOW, PAT_FAST: begin
					// a zero half period acts like one: toggle every tick
					if (ph_inc >= {1'b0, half}) begin
						ph_d    = 16'd0;
						drv_en  = 1'b1;
						drv_lvl = !lit_q;
					end else begin
						ph_d = ph_inc[15:0];
					end
				end
				default: begin
					drv_en  = 1'b1;
					drv_lvl = (cur_q == PAT_SOLID);
				end
			endcase
		end else if (cmd.set && (cmd.pattern != cur_q)) begin
			adopt     = 1'b1;
			adopt_pat = cmd.pattern;
		end else if (cmd.pulse) begin
			// first pulse of a run keeps the pattern to return to
			if (rem_q == 16'd0) begin
				sav_d = cur_q;
			end
			cur_d   = PAT_PULSE;
			rem_d   = plen_eff;
			drv_en  = 1'b1;
			drv_lvl = 1'b1;
		end

		// Restart on a new pattern and drive its level; a pulse pattern leaves the level alone
		if (adopt) begin
			cur_d = adopt_pat;
			ph_d  = 16'd0;
			rem_d = 16'd0;
			case (adopt_pat) inside
				PAT_OFF: begin
					drv_en  = 1'b1;
					drv_lvl = 1'b0;
				end
				PAT_SOLID, PAT_SLOW, PAT_FAST: begin
					drv_en  = 1'b1;
					drv_lvl = 1'b1;
				end
				default: begin
					drv_en = 1'b0;
				end
			endcase
		end

		lit_d = drv_en ? drv_lvl : lit_q;
		tr_d  = (lit_d != lit_q) ? tr_q + 32'd1 : tr_q;
	end

	// Hold lamp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= PAT_OFF;
			sav_q <= PAT_OFF;
			ph_q  <= 16'd0;
			rem_q <= 16'd0;
			lit_q <= 1'b0;
			tr_q  <= 32'd0;
		end else begin
			cur_q <= cur_d;
			sav_q <= sav_d;
			ph_q  <= ph_d;
			rem_q <= rem_d;
			lit_q <= lit_d;
			tr_q  <= tr_d;
		end
	end

	assign state.pattern     = cur_q;
	assign state.lit         = lit_q;
	assign state.transitions = tr_q;
	assign lit_next          = lit_d;

	// A level change bumps the count by one
	a_lit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(lit_q != $past(lit_q)) |-> (tr_q == $past(tr_q) + 32'd1))
		else $error("level change not counted");

	// The count moves only with the level
	a_count_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(tr_q != $past(tr_q)) |-> (lit_q != $past(lit_q)))
		else $error("count moved without a level change");

	// A running pulse keeps the lamp lit
	a_pulse_lit: assert property (@(posedge clk) disable iff (!arst_n)
		((cur_q == PAT_PULSE) && (rem_q != 16'd0)) |-> lit_q)
		else $error("lamp dark during a pulse");

endmodule

### rtl/ipc_out_buf.sv
// ----------------------------------------------------------------------------
// ipc_out_buf: two-entry result queue
// Holds finished results so that new beats are taken while the receiver
// stalls; the output payload comes straight from a queue register.
// ----------------------------------------------------------------------------
module ipc_out_buf
	import ipc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    not_full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign not_full  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];

	// Store a result beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### tb/sv/lamp_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lamp_check_pkg: expected-result tracking for the indicator lamp controller
// Keeps a private copy of every lamp's pattern, phase, pulse count, level and
// transition count, computes the result of each accepted command beat, and
// compares the results leaving the block against them in order.
// ----------------------------------------------------------------------------
package lamp_check_pkg;
	import ipc_pkg::*;

	class lamp_scoreboard;
		logic [15:0] slow_half;
		logic [15:0] fast_half;
		logic [15:0] pulse_len;
		logic [2:0]  cur_pat    [LAMPS];
		logic [2:0]  saved_pat  [LAMPS];
		logic [15:0] phase_cnt  [LAMPS];
		logic [15:0] pulse_left [LAMPS];
		logic        lit        [LAMPS];
		logic [31:0] flips      [LAMPS];
		result_t     expected_results [$];
		int          errors;

		function new();
			int i;
			slow_half = SLOW_HALF_RST;
			fast_half = FAST_HALF_RST;
			pulse_len = PULSE_LEN_RST;
			for (i = 0; i < LAMPS; i++) begin
				cur_pat[i]    = PAT_OFF;
				saved_pat[i]  = PAT_OFF;
				phase_cnt[i]  = '0;
				pulse_left[i] = '0;
				lit[i]        = 1'b0;
				flips[i]      = '0;
			end
			errors = 0;
		endfunction

		// Mirror a register write; unknown indexes are dropped
		function void load_register(logic [1:0] idx, logic [15:0] value);
			case (idx)
				CFG_SLOW_HALF: slow_half = value;
				CFG_FAST_HALF: fast_half = value;
				CFG_PULSE_LEN: pulse_len = value;
				default: ;
			endcase
		endfunction

		// Count only real level changes
		function void drive_lamp(int i, logic level);
			if (lit[i] != level) begin
				lit[i]   = level;
				flips[i] = flips[i] + 32'd1;
			end
		endfunction

		// Restart a lamp on a new pattern; pulse leaves the level alone
		function void adopt_pattern(int i, logic [2:0] pat);
			cur_pat[i]    = pat;
			phase_cnt[i]  = '0;
			pulse_left[i] = '0;
			if (pat == PAT_OFF)
				drive_lamp(i, 1'b0);
			else if (pat == PAT_SOLID || pat == PAT_SLOW || pat == PAT_FAST)
				drive_lamp(i, 1'b1);
		endfunction

		// Advance one lamp by one tick
		function void tick_lamp(int i);
			logic [16:0] next_phase;
			logic [15:0] half;
			if (cur_pat[i] == PAT_PULSE) begin
				if (pulse_left[i] != 0)
					pulse_left[i] = pulse_left[i] - 16'd1;
				if (pulse_left[i] == 0)
					adopt_pattern(i, saved_pat[i]);
			end else if (cur_pat[i] == PAT_SLOW || cur_pat[i] == PAT_FAST) begin
				half = (cur_pat[i] == PAT_SLOW) ? slow_half : fast_half;
				next_phase = {1'b0, phase_cnt[i]} + 17'd1;
				// A zero half period toggles on every tick, same as one
				if (next_phase >= {1'b0, half}) begin
					phase_cnt[i] = '0;
					drive_lamp(i, !lit[i]);
				end else begin
					phase_cnt[i] = next_phase[15:0];
				end
			end else begin
				drive_lamp(i, cur_pat[i] == PAT_SOLID);
			end
		endfunction

		// Work out the result of one accepted command beat and queue it
		function void accept_command(logic [1:0] op, logic [3:0] ind, logic [2:0] pat);
			result_t r;
			int i;
			r = '0;
			if (op == OP_TICK) begin
				for (i = 0; i < LAMPS; i++)
					tick_lamp(i);
			end else if (ind >= LAMPS) begin
				r.status = STAT_BAD_LAMP;
			end else if (op == OP_SET) begin
				if (pat > PAT_PULSE)
					r.status = STAT_BAD_PATRN;
				else if (cur_pat[ind] != pat)
					adopt_pattern(ind, pat);
			end else if (op == OP_PULSE) begin
				// Only the first pulse of a run saves the pattern to restore
				if (pulse_left[ind] == 0)
					saved_pat[ind] = cur_pat[ind];
				cur_pat[ind]    = PAT_PULSE;
				pulse_left[ind] = (pulse_len == 0) ? 16'd1 : pulse_len;
				drive_lamp(ind, 1'b1);
			end else begin
				r.query_pattern     = cur_pat[ind];
				r.query_lit         = lit[ind];
				r.query_transitions = flips[ind];
			end
			for (i = 0; i < LAMPS && i < LEVEL_BITS; i++)
				r.lamp_levels[i] = lit[i];
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ERROR: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		// Compare a result beat against the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t ERROR: unexpected result beat, expected none, got status %0d",
					$time, got.status);
			end else begin
				want = expected_results.pop_front();
				compare_field("status", 32'(want.status), 32'(got.status));
				compare_field("lamp_levels", 32'(want.lamp_levels),
					32'(got.lamp_levels));
				compare_field("query_pattern", 32'(want.query_pattern),
					32'(got.query_pattern));
				compare_field("query_lit", 32'(want.query_lit), 32'(got.query_lit));
				compare_field("query_transitions", want.query_transitions,
					got.query_transitions);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for indicator_pattern_controller
// Drives a directed opening sequence and then weighted random command beats
// over several register settings, with random gaps and stalls on both sides
// and long output hold-offs that back the block up. Every result beat is
// checked field by field against the scoreboard's own lamp tracking.
// ----------------------------------------------------------------------------
module tb_top;
	import ipc_pkg::*;
	import lamp_check_pkg::*;

	// Index with no register behind it
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 75;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            op;
	logic [3:0]            indicator;
	logic [2:0]            pattern;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            status;
	logic [LEVEL_BITS-1:0] lamp_levels;
	logic [2:0]            query_pattern;
	logic                  query_lit;
	logic [31:0]           query_transitions;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [15:0]           cfg_data;

	lamp_scoreboard lamps_sb;
	int tx_count = 0;
	int rx_count = 0;

	indicator_pattern_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.indicator(indicator),
		.pattern(pattern),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.lamp_levels(lamp_levels),
		.query_pattern(query_pattern),
		.query_lit(query_lit),
		.query_transitions(query_transitions),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Random wait per beat, with stretches of back-to-back beats
	function automatic int pick_wait(int n);
		if ((n / 40) % 5 == 4)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// Offer one command beat and hold it until accepted
	task automatic send_item(input logic [1:0] o, input logic [3:0] ind,
			input logic [2:0] p);
		int gap;
		gap = pick_wait(tx_count);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		indicator <= ind;
		pattern   <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		lamps_sb.accept_command(o, ind, p);
		tx_count++;
	endtask

	// Mostly valid lamps and patterns, with some bad ones mixed in
	task automatic send_random_item();
		logic [1:0] o;
		logic [3:0] ind;
		logic [2:0] p;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			o = OP_TICK;
		else if (roll < 65)
			o = OP_SET;
		else if (roll < 80)
			o = OP_PULSE;
		else
			o = OP_QUERY;
		if ($urandom_range(0, 9) == 0)
			ind = 4'($urandom_range(LAMPS, 15));
		else
			ind = 4'($urandom_range(0, LAMPS - 1));
		if ($urandom_range(0, 9) == 0)
			p = 3'($urandom_range(PAT_PULSE + 1, 7));
		else
			p = 3'($urandom_range(PAT_OFF, PAT_PULSE));
		send_item(o, ind, p);
	endtask

	// Drop valid and wait until every result beat is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (lamps_sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		lamps_sb.load_register(idx, value);
	endtask

	task automatic write_setting(input logic [15:0] slow, input logic [15:0] fast,
			input logic [15:0] plen);
		write_register(CFG_SLOW_HALF, slow);
		write_register(CFG_FAST_HALF, fast);
		write_register(CFG_PULSE_LEN, plen);
		write_register(CFG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Result side: random stalls plus long hold-offs to fill the block
	initial begin : result_sink
		int stall;
		result_t got;
		out_ready <= 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_count == 30 || rx_count % 200 == 120)
				stall = 60;
			else
				stall = pick_wait(rx_count);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got.status            = status;
			got.lamp_levels       = lamp_levels;
			got.query_pattern     = query_pattern;
			got.query_lit         = query_lit;
			got.query_transitions = query_transitions;
			lamps_sb.check_result(got);
			rx_count++;
		end
	end

	initial begin : stimulus
		int setting;
		int n;
		lamps_sb = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		op        <= OP_TICK;
		indicator <= '0;
		pattern   <= PAT_OFF;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_SLOW_HALF;
		cfg_data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening under the reset register values
		send_item(OP_QUERY, 4'd0, PAT_OFF);
		send_item(OP_SET,   4'd0, PAT_SOLID);
		send_item(OP_SET,   4'd0, PAT_SOLID);        // unchanged, ignored
		send_item(OP_SET,   4'd1, PAT_SLOW);
		send_item(OP_SET,   4'd2, PAT_FAST);
		send_item(OP_SET,   4'd3, 3'd7);             // bad pattern
		send_item(OP_SET,   4'd15, 3'd7);            // bad lamp wins over bad pattern
		send_item(OP_PULSE, 4'(LAMPS), PAT_OFF);
		send_item(OP_QUERY, 4'd15, 3'd7);
		send_item(OP_TICK,  4'd15, 3'd7);            // fields ignored on tick
		send_item(OP_PULSE, 4'd4, 3'd7);             // pattern ignored on pulse
		send_item(OP_TICK,  4'd0, PAT_OFF);
		send_item(OP_PULSE, 4'd4, PAT_OFF);          // pulse again mid-run
		send_item(OP_TICK,  4'd0, PAT_OFF);
		send_item(OP_TICK,  4'd0, PAT_OFF);
		send_item(OP_QUERY, 4'd4, PAT_OFF);
		send_item(OP_SET,   4'd3, PAT_PULSE);        // set to pulse, then pulse
		send_item(OP_PULSE, 4'd3, PAT_OFF);
		send_item(OP_TICK,  4'd0, PAT_OFF);
		send_item(OP_TICK,  4'd0, PAT_OFF);
		send_item(OP_TICK,  4'd0, PAT_OFF);
		send_item(OP_QUERY, 4'd3, PAT_OFF);
		send_item(OP_SET,   4'd3, PAT_OFF);
		send_item(OP_SET,   4'd0, 3'd5);
		send_item(OP_QUERY, 4'd1, 3'd6);
		send_item(OP_QUERY, 4'd2, PAT_OFF);

		// Random phases, each under its own register setting
		for (setting = 0; setting < PHASES; setting++) begin
			wait_idle();
			case (setting)
				0: write_setting(16'd1, 16'd1, 16'd1);
				1: write_setting(16'd0, 16'd0, 16'd0);
				2: write_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: write_setting(16'hFFFF, 16'd3, 16'd1);
				default: write_setting(16'($urandom_range(1, 8)),
					16'($urandom_range(1, 4)), 16'($urandom_range(1, 6)));
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_random_item();
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (lamps_sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
rtl/ipc_pkg.sv
rtl/ipc_lamp.sv
rtl/ipc_out_buf.sv
rtl/indicator_pattern_controller.sv
tb/sv/lamp_check_pkg.sv
tb/sv/tb_top.sv
